FILE: rtl/kedr_pkg.sv
// ----------------------------------------------------------------------------
// kedr_pkg: shared types and constants for the key event decoder
// Item, result, configuration and tracking-state records, command and
// register codes, and the keycode limits.
// ----------------------------------------------------------------------------
package kedr_pkg;

	// command carried in the slave-side tuser
	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_POLL   = 2'd1,
		OP_CLEAR  = 2'd2
	} kedr_op_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CTRL_RELEASE = 3'd0,
		REG_CTRL_HOLD    = 3'd1,
		REG_PRESSED      = 3'd2,
		REG_DELAY        = 3'd3,
		REG_RATE         = 3'd4
	} kedr_reg_t;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned S_TDATA_W  = 56;
	localparam int unsigned M_TDATA_W  = 8;

	localparam logic [7:0] KEY_MAX = 8'h7E;
	localparam logic [7:0] CHAR_A  = 8'h61;
	localparam logic [7:0] CHAR_Z  = 8'h7A;

	localparam logic [15:0] RST_CTRL_RELEASE = 16'hA503;
	localparam logic [15:0] RST_CTRL_HOLD    = 16'hA501;
	localparam logic [7:0]  RST_PRESSED      = 8'd1;
	localparam logic [15:0] RST_DELAY        = 16'd500;
	localparam logic [15:0] RST_RATE         = 16'd100;

	typedef struct packed {
		logic [15:0] ctrl_release_word;
		logic [15:0] ctrl_hold_word;
		logic [7:0]  pressed_status;
		logic [15:0] repeat_delay_ms;
		logic [15:0] repeat_rate_ms;
	} kedr_cfg_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] report_word;
		logic        read_failed;
		logic [31:0] now_ms;
	} kedr_item_t;

	typedef struct packed {
		logic       key_valid;
		logic [6:0] key_code;
		logic       is_repeat;
		logic       ctrl_active;
	} kedr_result_t;

	typedef struct packed {
		logic        ctrl_held;
		logic        tracked_valid;
		logic [6:0]  tracked_key;
		logic        press_consumed;
		logic [31:0] press_time;
		logic [31:0] repeat_time;
		logic        repeat_started;
	} kedr_state_t;

endpackage

FILE: rtl/kedr_cfg.sv
// ----------------------------------------------------------------------------
// kedr_cfg: configuration register file
// Five write-only registers loaded through a plain index/data write port.
// ----------------------------------------------------------------------------
module kedr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kedr_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [kedr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output kedr_pkg::kedr_cfg_t            cfg
);
	import kedr_pkg::*;

	kedr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ctrl_release_word <= RST_CTRL_RELEASE;
			cfg_q.ctrl_hold_word    <= RST_CTRL_HOLD;
			cfg_q.pressed_status    <= RST_PRESSED;
			cfg_q.repeat_delay_ms   <= RST_DELAY;
			cfg_q.repeat_rate_ms    <= RST_RATE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CTRL_RELEASE: cfg_q.ctrl_release_word <= cfg_wdata;
				REG_CTRL_HOLD:    cfg_q.ctrl_hold_word    <= cfg_wdata;
				REG_PRESSED:      cfg_q.pressed_status    <= cfg_wdata[7:0];
				REG_DELAY:        cfg_q.repeat_delay_ms   <= cfg_wdata;
				REG_RATE:         cfg_q.repeat_rate_ms    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/kedr_decode.sv
// ----------------------------------------------------------------------------
// kedr_decode: key decode and typematic repeat state
// Works out one result word from the registered item and the tracking
// state, and updates that state when the item advances.
// ----------------------------------------------------------------------------
module kedr_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  kedr_pkg::kedr_item_t   item,
	input  kedr_pkg::kedr_cfg_t    cfg,
	output kedr_pkg::kedr_result_t result
);
	import kedr_pkg::*;

	kedr_state_t st_q;
	kedr_state_t st_nxt;
	logic [7:0]  status;
	logic [7:0]  key;
	logic [7:0]  ctrl_off;
	logic [31:0] since_press;
	logic [31:0] since_repeat;

	assign status       = item.report_word[7:0];
	assign key          = item.report_word[15:8];
	assign ctrl_off     = key - CHAR_A;
	assign since_press  = item.now_ms - st_q.press_time;
	assign since_repeat = item.now_ms - st_q.repeat_time;

	always_comb begin
		st_nxt           = st_q;
		result           = '0;
		case (item.operation)
			OP_REPORT: begin
				if (!item.read_failed && item.report_word != 16'd0) begin
					if (item.report_word == cfg.ctrl_release_word) begin
						st_nxt.ctrl_held = 1'b0;
					end else if (item.report_word == cfg.ctrl_hold_word) begin
						st_nxt.ctrl_held = 1'b1;
					end else if (status != cfg.pressed_status) begin
						st_nxt.tracked_valid  = 1'b0;
						st_nxt.press_consumed = 1'b0;
					end else if (key != 8'd0 && key <= KEY_MAX) begin
						if (st_q.ctrl_held && (key inside {[CHAR_A:CHAR_Z]})) begin
							// control code, never repeats
							st_nxt.tracked_valid  = 1'b0;
							st_nxt.press_consumed = 1'b0;
							result.key_valid      = 1'b1;
							result.key_code       = ctrl_off[6:0] + 7'd1;
						end else if (!(st_q.tracked_valid && st_q.press_consumed &&
						               key[6:0] == st_q.tracked_key)) begin
							st_nxt.tracked_valid  = 1'b1;
							st_nxt.tracked_key    = key[6:0];
							st_nxt.press_time     = item.now_ms;
							st_nxt.repeat_time    = '0;
							st_nxt.repeat_started = 1'b0;
							st_nxt.press_consumed = 1'b1;
							result.key_valid      = 1'b1;
							result.key_code       = key[6:0];
						end
					end
				end
			end
			OP_POLL: begin
				if (st_q.tracked_valid && since_press >= {16'd0, cfg.repeat_delay_ms} &&
				    (!st_q.repeat_started ||
				     since_repeat >= {16'd0, cfg.repeat_rate_ms})) begin
					st_nxt.repeat_time    = item.now_ms;
					st_nxt.repeat_started = 1'b1;
					result.key_valid      = 1'b1;
					result.key_code       = st_q.tracked_key;
					result.is_repeat      = 1'b1;
				end
			end
			OP_CLEAR: begin
				st_nxt.tracked_valid  = 1'b0;
				st_nxt.press_consumed = 1'b0;
			end
			default: ;
		endcase
		result.ctrl_active = st_nxt.ctrl_held;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

endmodule

FILE: rtl/key_event_decoder_with_repeat.sv
// ----------------------------------------------------------------------------
// key_event_decoder_with_repeat: keyboard report decoder with auto-repeat
// Turns key reports, repeat polls and clear commands into character words.
// ----------------------------------------------------------------------------
// Usage
//   Slave side: one word per command. s_tuser holds the command (report,
//   poll, clear); s_tdata the report word, the read-failed flag and the
//   millisecond time stamp.
//   Master side: exactly one result word per command, in order. m_tuser
//   flags a delivered character and whether it came from auto-repeat;
//   m_tdata holds the character code and the current Ctrl flag.
//   Configuration: cfg_we with cfg_addr/cfg_wdata loads one register per
//   cycle; write only while no command is in flight.
// Timing
//   An accepted word lands in an input register; combinational decode
//   feeds the result register and m_tvalid, held off while the result
//   register is full and m_tready is low. One word per cycle is sustained
//   while m_tready stays high, limited only by the single decode stage.
// Reset and stall
//   arst_n clears the Ctrl flag, key tracking and both pipeline valid
//   flags and restores the register defaults. When m_tready is low the
//   result holds; one further word is still taken into the input register.
// ----------------------------------------------------------------------------
module key_event_decoder_with_repeat (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata: report_word[15:0], read_failed[16], now_ms[48:17], zero pad
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [kedr_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [1:0]                      s_tuser,   // operation[1:0]
	// m_tdata: key_code[6:0], ctrl_active[7]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [kedr_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [1:0]                      m_tuser,   // key_valid[0], is_repeat[1]
	input  logic                            cfg_we,
	input  logic [kedr_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [kedr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import kedr_pkg::*;

	kedr_cfg_t    cfg;
	kedr_item_t   item_s1;
	logic         valid_s1;
	kedr_result_t res_comb;
	kedr_result_t res_s2;
	logic         valid_s2;
	logic         advance;
	logic         s_accept;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	kedr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	kedr_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.operation   <= s_tuser;
			item_s1.report_word <= s_tdata[15:0];
			item_s1.read_failed <= s_tdata[16];
			item_s1.now_ms      <= s_tdata[48:17];
		end
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.ctrl_active, res_s2.key_code};
	assign m_tuser  = {res_s2.is_repeat, res_s2.key_valid};

endmodule

FILE: rtl/kedr_checker.sv
// ----------------------------------------------------------------------------
// kedr_checker: port-level checks for the key event decoder
// Watches the stream ports and flags broken results or handshakes.
// ----------------------------------------------------------------------------
module kedr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [kedr_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic [1:0]                      m_tuser
);

	// hold the result while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// an empty result register never blocks the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output empty");

	// no character: code and repeat flag read zero
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[6:0] == 7'd0 && !m_tuser[1])
		else $error("stray code on empty result");

	// delivered codes stay within the printable/control range
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[6:0] != 7'd0 && m_tdata[6:0] != 7'h7F)
		else $error("delivered code out of range");

endmodule

bind key_event_decoder_with_repeat kedr_checker u_kedr_checker (.*);
